@@ hdl/wsd_pkg.sv @@
// Shared types and constants for the WebSocket text frame deframer.
package wsd_pkg;

  localparam int unsigned LEN_WIDTH_DEF = 64;

  localparam logic [7:0] BYTE_FRAME_START = 8'h81;  // FIN set, opcode text
  localparam logic [7:0] BYTE_JSON_OPEN   = 8'h7b;  // '{'
  localparam logic [6:0] LEN7_MASK        = 7'h7f;
  localparam logic [6:0] LEN7_EXT16       = 7'd126;
  localparam logic [6:0] LEN7_EXT64       = 7'd127;

  localparam logic [2:0] EXT16_COUNT = 3'd1;  // bytes left after the first
  localparam logic [2:0] EXT64_COUNT = 3'd7;
  localparam logic [2:0] MASK_COUNT  = 3'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_EXT,
    PH_MASK,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       segment_start;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
    logic       aborted;
  } payload_item_t;

  typedef struct packed {
    logic          valid;
    payload_item_t item;
  } step_result_t;

endpackage

@@ hdl/websocket_text_frame_deframer_top.sv @@
// Top level of the WebSocket text frame deframer: input and result registers.
//
// Takes one stream byte per cycle while stream_stall is low and returns the
// unmasked payload of unfragmented text frames that start with '{', marking the
// last byte, plus an abort transaction when a new frame start cuts off a frame
// already partly forwarded. Throughput is one byte per clock when not stalled.
// An accepted byte passes through the input register, and its result, if any,
// is then written to the result register. The header state machine and length
// counter update as the byte leaves the input register.
// stream_stall follows payload_stall combinationally when the input register
// holds a byte that produces a result and the result register is full and
// stalled.
module websocket_text_frame_deframer_top import wsd_pkg::*; #(
  parameter int unsigned LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          stream_valid,
  output logic          stream_stall,
  input  stream_item_t  stream_item,
  output logic          payload_valid,
  input  logic          payload_stall,
  output payload_item_t payload_item
);

  logic         in_valid;
  stream_item_t in_item;
  step_result_t step;
  logic         out_free;
  logic         advance;

  assign out_free     = !payload_valid || !payload_stall;
  assign advance      = in_valid && (!step.valid || out_free);
  assign stream_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!stream_stall) begin
      in_valid <= stream_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stream_stall && stream_valid) begin
      in_item <= stream_item;
    end
  end

  wsd_parser #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .item    (in_item),
    .advance (advance),
    .result  (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_valid <= 1'b0;
    end else if (advance && step.valid) begin
      payload_valid <= 1'b1;
    end else if (!payload_stall) begin
      payload_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.valid) begin
      payload_item <= step.item;
    end
  end

endmodule

@@ hdl/wsd_parser.sv @@
// Frame header state machine, length counter and payload unmasking.
module wsd_parser import wsd_pkg::*; #(
  parameter int unsigned LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  stream_item_t item,
  input  logic         advance,
  output step_result_t result
);

  phase_t               phase, phase_next;
  logic [LEN_WIDTH-1:0] length_remaining, length_remaining_next;
  logic [2:0]           header_byte_count, header_byte_count_next;
  logic [31:0]          mask_key, mask_key_next;
  logic                 mask_present, mask_present_next;
  logic [1:0]           payload_index, payload_index_next;
  logic                 forwarding, forwarding_next;
  logic                 skip, skip_next;

  logic                 seg;
  logic [7:0]           b;
  logic [6:0]           len7;
  logic                 is_start;
  logic                 restart;
  logic                 idle_seg;
  logic                 skipped;
  logic [7:0]           key_byte;
  logic [7:0]           data_val;
  logic [LEN_WIDTH-1:0] len_dec;
  logic                 data_last;
  logic                 first_dec;
  logic                 fwd_now;
  logic                 ext_sat;
  logic [LEN_WIDTH-1:0] ext_len;

  assign seg      = item.segment_start;
  assign b        = item.data_byte;
  assign len7     = b[6:0] & LEN7_MASK;
  assign is_start = (b == BYTE_FRAME_START);
  assign restart  = seg && is_start;
  assign idle_seg = seg && !is_start && (phase == PH_IDLE);
  assign skipped  = !seg && skip;

  // key byte 0 is the most significant byte of the key register
  assign key_byte  = mask_key[{~payload_index, 3'b000} +: 8];
  assign data_val  = mask_present ? (b ^ key_byte) : b;
  assign len_dec   = length_remaining - LEN_WIDTH'(1);
  assign data_last = (len_dec == '0);
  assign first_dec = (payload_index == 2'd0) && !forwarding && (header_byte_count == 3'd0);
  assign fwd_now   = first_dec ? (data_val == BYTE_JSON_OPEN) : forwarding;

  // extended length saturates once the top byte would be shifted out
  assign ext_sat = (length_remaining[LEN_WIDTH-1 -: 8] != 8'd0);
  assign ext_len = ext_sat ? '1 : {length_remaining[LEN_WIDTH-9:0], b};

  always_comb begin
    phase_next             = phase;
    length_remaining_next  = length_remaining;
    header_byte_count_next = header_byte_count;
    mask_key_next          = mask_key;
    mask_present_next      = mask_present;
    payload_index_next     = payload_index;
    forwarding_next        = forwarding;
    skip_next              = skip;
    priority if (restart || (!seg && !skip && phase == PH_IDLE && is_start)) begin
      phase_next             = PH_LEN;
      length_remaining_next  = '0;
      header_byte_count_next = 3'd0;
      mask_key_next          = '0;
      mask_present_next      = 1'b0;
      payload_index_next     = 2'd0;
      forwarding_next        = 1'b0;
      skip_next              = 1'b0;
    end else if (idle_seg) begin
      skip_next = 1'b1;
    end else if (skipped) begin
      skip_next = skip;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          skip_next = 1'b1;
        end
        PH_LEN: begin
          mask_present_next     = b[7];
          length_remaining_next = '0;
          priority if (len7 == LEN7_EXT16) begin
            phase_next             = PH_EXT;
            header_byte_count_next = EXT16_COUNT;
          end else if (len7 == LEN7_EXT64) begin
            phase_next             = PH_EXT;
            header_byte_count_next = EXT64_COUNT;
          end else begin
            length_remaining_next = LEN_WIDTH'(len7);
            priority if (b[7]) begin
              phase_next             = PH_MASK;
              header_byte_count_next = MASK_COUNT;
            end else if (len7 == 7'd0) begin
              phase_next = PH_IDLE;
            end else begin
              phase_next         = PH_DATA;
              payload_index_next = 2'd0;
            end
          end
        end
        PH_EXT: begin
          length_remaining_next = ext_len;
          if (header_byte_count == 3'd0) begin
            priority if (mask_present) begin
              phase_next             = PH_MASK;
              header_byte_count_next = MASK_COUNT;
            end else if (ext_len == '0) begin
              phase_next = PH_IDLE;
            end else begin
              phase_next         = PH_DATA;
              payload_index_next = 2'd0;
            end
          end else begin
            header_byte_count_next = header_byte_count - 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], b};
          if (header_byte_count == 3'd0) begin
            mask_present_next  = 1'b1;
            phase_next         = (length_remaining == '0) ? PH_IDLE : PH_DATA;
            payload_index_next = 2'd0;
          end else begin
            header_byte_count_next = header_byte_count - 3'd1;
          end
        end
        PH_DATA: begin
          payload_index_next    = payload_index + 2'd1;
          length_remaining_next = len_dec;
          if (first_dec) begin
            forwarding_next        = fwd_now;
            header_byte_count_next = 3'd1;  // first payload byte seen
          end
          if (data_last) begin
            phase_next             = PH_IDLE;
            forwarding_next        = 1'b0;
            header_byte_count_next = 3'd0;
            payload_index_next     = 2'd0;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          skip_next  = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    result = '0;
    priority if (restart) begin
      // abort only if part of the dropped frame went out
      result.valid        = (phase != PH_IDLE) && forwarding;
      result.item.aborted = 1'b1;
    end else if (!idle_seg && !skipped && phase == PH_DATA) begin
      result.valid             = fwd_now;
      result.item.payload_byte = data_val;
      result.item.last_byte    = data_last;
    end else begin
      result = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      length_remaining  <= '0;
      header_byte_count <= 3'd0;
      mask_key          <= '0;
      mask_present      <= 1'b0;
      payload_index     <= 2'd0;
      forwarding        <= 1'b0;
      skip              <= 1'b0;
    end else if (advance) begin
      phase             <= phase_next;
      length_remaining  <= length_remaining_next;
      header_byte_count <= header_byte_count_next;
      mask_key          <= mask_key_next;
      mask_present      <= mask_present_next;
      payload_index     <= payload_index_next;
      forwarding        <= forwarding_next;
      skip              <= skip_next;
    end
  end

  a_skip_only_idle: assert property (@(posedge clk) disable iff (rst)
    skip |-> phase == PH_IDLE)
    else $error("segment skip active outside idle");

  a_data_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> length_remaining != '0)
    else $error("payload phase with zero length left");

  a_fwd_only_data: assert property (@(posedge clk) disable iff (rst)
    forwarding |-> phase == PH_DATA)
    else $error("forwarding set outside payload phase");

  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_MASK |-> header_byte_count <= MASK_COUNT)
    else $error("mask key byte count out of range");

endmodule

@@ verif/websocket_text_frame_deframer_top_test.sv @@
// Self-checking testbench for the WebSocket text frame deframer top level.
`timescale 1ns / 1ps

module websocket_text_frame_deframer_top_test;
  import wsd_pkg::*;

  localparam int unsigned LW           = LEN_WIDTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned HANG_CYCLES  = 2000;
  localparam logic [2:0]  FIRST_SEEN   = 3'd1;  // first payload byte already judged

  logic          clk;
  logic          rst = 1'b1;
  logic          stream_valid = 1'b0;
  logic          stream_stall;
  stream_item_t  stream_item = '0;
  logic          payload_valid;
  logic          payload_stall = 1'b0;
  payload_item_t payload_item;

  websocket_text_frame_deframer_top dut (
    .clk,
    .rst,
    .stream_valid,
    .stream_stall,
    .stream_item,
    .payload_valid,
    .payload_stall,
    .payload_item
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Predictor state
  phase_t        fr_phase;
  logic [LW-1:0] len_left;
  logic [2:0]    hdr_left;
  logic [31:0]   key;
  logic          masked;
  logic [1:0]    pidx;
  logic          fwd;
  logic          skipping;

  stream_item_t  byte_backlog[$];
  payload_item_t payload_due[$];
  step_result_t  next_out;
  int unsigned   total_items;
  int unsigned   sent_count;
  int unsigned   errors;
  int unsigned   gap_left;
  int unsigned   stall_left;
  int unsigned   tx_burst;
  int unsigned   rx_burst;
  int unsigned   idle_cycles;

  function automatic void open_frame();
    fr_phase = PH_LEN;
    len_left = '0;
    hdr_left = '0;
    key      = '0;
    masked   = 1'b0;
    pidx     = '0;
    fwd      = 1'b0;
    skipping = 1'b0;
  endfunction

  function automatic void close_header();
    if (masked) begin
      fr_phase = PH_MASK;
      hdr_left = MASK_COUNT;
    end else if (len_left == '0) begin
      fr_phase = PH_IDLE;
    end else begin
      fr_phase = PH_DATA;
      pidx = '0;
    end
  endfunction

  function automatic step_result_t deframe_byte(stream_item_t it);
    step_result_t r;
    logic [7:0]   b;
    logic [7:0]   v;
    logic         emit;
    logic         first;
    r = '0;
    b = it.data_byte;
    if (it.segment_start) begin
      if (b == BYTE_FRAME_START) begin
        emit = (fr_phase != PH_IDLE) && fwd;
        open_frame();
        if (emit) begin
          r.valid = 1'b1;
          r.item.aborted = 1'b1;
        end
        return r;
      end
      if (fr_phase == PH_IDLE) begin
        skipping = 1'b1;
        return r;
      end
    end else if (skipping) begin
      return r;
    end

    case (fr_phase)
      PH_IDLE: begin
        if (b == BYTE_FRAME_START) open_frame();
        else skipping = 1'b1;
      end
      PH_LEN: begin
        masked = b[7];
        len_left = '0;
        if (b[6:0] == LEN7_EXT16) begin
          fr_phase = PH_EXT;
          hdr_left = EXT16_COUNT;
        end else if (b[6:0] == LEN7_EXT64) begin
          fr_phase = PH_EXT;
          hdr_left = EXT64_COUNT;
        end else begin
          len_left = LW'(b[6:0]);
          close_header();
        end
      end
      PH_EXT: begin
        // saturate rather than shift bits out the top
        if (len_left[LW-1 -: 8] != '0) len_left = '1;
        else len_left = {len_left[LW-9:0], b};
        if (hdr_left == '0) close_header();
        else hdr_left = hdr_left - 3'd1;
      end
      PH_MASK: begin
        key = {key[23:0], b};
        if (hdr_left == '0) begin
          masked = 1'b1;
          fr_phase = (len_left == '0) ? PH_IDLE : PH_DATA;
          pidx = '0;
        end else begin
          hdr_left = hdr_left - 3'd1;
        end
      end
      PH_DATA: begin
        v = b;
        if (masked) v = v ^ key[8*(3 - pidx) +: 8];
        first = (pidx == 2'd0) && !fwd;
        pidx = pidx + 2'd1;
        len_left = len_left - 1'b1;
        if (hdr_left == '0 && first) begin
          fwd = (v == BYTE_JSON_OPEN);
          hdr_left = FIRST_SEEN;
        end
        if (len_left == '0) begin
          r.valid = fwd;
          r.item.payload_byte = v;
          r.item.last_byte = 1'b1;
          fr_phase = PH_IDLE;
          fwd = 1'b0;
          hdr_left = '0;
          pidx = '0;
        end else if (fwd) begin
          r.valid = 1'b1;
          r.item.payload_byte = v;
        end
      end
      default: begin
        fr_phase = PH_IDLE;
        skipping = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic stream_item_t mk(logic [7:0] b, logic seg);
    stream_item_t it;
    it.data_byte = b;
    it.segment_start = seg;
    return it;
  endfunction

  function automatic logic mid_seg();
    return ($urandom_range(0, 11) == 0);
  endfunction

  function automatic int unsigned pick_idle(inout int unsigned burst);
    int unsigned r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) begin
      burst = $urandom_range(30, 150);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic add_frame(input bit hdr_seg, output bit cut_short);
    stream_item_t frame_q[$];
    int unsigned  plen;
    int unsigned  nsend;
    int unsigned  kind;
    int unsigned  drop;
    logic [63:0]  declared;
    logic [31:0]  mkey;
    logic [7:0]   plain;
    logic [7:0]   kbyte;
    logic [6:0]   len7;
    bit           use_mask;
    use_mask  = ($urandom_range(0, 3) != 0);
    mkey      = $urandom;
    kind      = $urandom_range(0, 19);
    cut_short = ($urandom_range(0, 7) == 0);
    if (kind < 12)
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 16);
    else if (kind < 16)
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 24);
    else
      plen = $urandom_range(0, 24);
    declared = 64'(plen);
    nsend = plen;
    if (kind == 19) begin
      // huge declared length: never completes, the next frame start cuts it off
      declared = {$urandom, $urandom};
      nsend = $urandom_range(1, 12);
      cut_short = 1'b1;
    end
    len7 = (kind < 12) ? plen[6:0] : (kind < 16) ? LEN7_EXT16 : LEN7_EXT64;

    frame_q.push_back(mk(BYTE_FRAME_START, hdr_seg));
    frame_q.push_back(mk({use_mask, len7}, mid_seg()));
    if (kind >= 12 && kind < 16) begin
      for (int i = 1; i >= 0; i--) frame_q.push_back(mk(declared[8*i +: 8], mid_seg()));
    end else if (kind >= 16) begin
      for (int i = 7; i >= 0; i--) frame_q.push_back(mk(declared[8*i +: 8], mid_seg()));
    end
    if (use_mask) begin
      for (int i = 3; i >= 0; i--) frame_q.push_back(mk(mkey[8*i +: 8], mid_seg()));
    end
    for (int unsigned i = 0; i < nsend; i++) begin
      plain = (i == 0 && $urandom_range(0, 9) < 7) ? BYTE_JSON_OPEN : 8'($urandom);
      kbyte = use_mask ? mkey[8*(3 - i % 4) +: 8] : 8'h00;
      frame_q.push_back(mk(plain ^ kbyte, mid_seg()));
    end
    if (cut_short && kind != 19) begin
      drop = $urandom_range(1, frame_q.size() - 1);
      repeat (drop) void'(frame_q.pop_back());
    end
    foreach (frame_q[i]) byte_backlog.push_back(frame_q[i]);
  endtask

  // Stimulus
  initial begin
    bit need_seg;
    open_frame();
    fr_phase = PH_IDLE;

    byte_backlog.push_back(mk(8'h00, 1'b0));                    // junk while idle
    byte_backlog.push_back(mk(BYTE_FRAME_START, 1'b0));         // swallowed by skip
    byte_backlog.push_back(mk(BYTE_FRAME_START, 1'b1));
    byte_backlog.push_back(mk(8'h83, 1'b0));                    // masked, length 3
    byte_backlog.push_back(mk(8'hff, 1'b0));
    byte_backlog.push_back(mk(8'h00, 1'b0));
    byte_backlog.push_back(mk(8'ha5, 1'b0));
    byte_backlog.push_back(mk(8'h5a, 1'b0));
    byte_backlog.push_back(mk(BYTE_JSON_OPEN ^ 8'hff, 1'b0));
    byte_backlog.push_back(mk(8'h7f ^ 8'h00, 1'b1));            // new segment continues frame
    byte_backlog.push_back(mk(8'h80 ^ 8'ha5, 1'b0));
    byte_backlog.push_back(mk(BYTE_FRAME_START, 1'b0));         // start without segment mark
    byte_backlog.push_back(mk({1'b0, LEN7_EXT16}, 1'b0));
    byte_backlog.push_back(mk(8'h00, 1'b0));
    byte_backlog.push_back(mk(8'h05, 1'b0));
    byte_backlog.push_back(mk(BYTE_JSON_OPEN, 1'b0));
    byte_backlog.push_back(mk(8'hff, 1'b0));
    byte_backlog.push_back(mk(BYTE_FRAME_START, 1'b1));         // cuts off forwarded frame
    byte_backlog.push_back(mk(8'h01, 1'b0));
    byte_backlog.push_back(mk(8'h00, 1'b0));                    // payload not a JSON object
    byte_backlog.push_back(mk(BYTE_FRAME_START, 1'b1));
    byte_backlog.push_back(mk(8'h00, 1'b0));                    // empty payload
    byte_backlog.push_back(mk(8'hff, 1'b1));                    // foreign segment
    byte_backlog.push_back(mk(BYTE_FRAME_START, 1'b0));

    need_seg = 1'b1;
    while (byte_backlog.size() < 24 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 6))
          byte_backlog.push_back(mk(8'($urandom), $urandom_range(0, 2) == 0));
        need_seg = 1'b1;
      end else begin
        add_frame(need_seg | ($urandom_range(0, 9) != 0), need_seg);
      end
    end
    total_items = byte_backlog.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (sent_count != total_items) @(posedge clk);
    while (payload_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      stream_valid <= 1'b0;
    end else begin
      if (stream_valid && !stream_stall) begin
        next_out = deframe_byte(stream_item);
        if (next_out.valid) payload_due.push_back(next_out.item);
        sent_count++;
      end
      if (!(stream_valid && stream_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          stream_valid <= 1'b0;
        end else if (byte_backlog.size() > 0) begin
          stream_item <= byte_backlog.pop_front();
          stream_valid <= 1'b1;
          gap_left = pick_idle(tx_burst);
        end else begin
          stream_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    payload_item_t exp_item;
    if (rst) begin
      payload_stall <= 1'b0;
    end else begin
      if (payload_valid && !payload_stall) begin
        if (payload_due.size() == 0) begin
          note_error($sformatf("unexpected transaction: byte %02h last %0b abort %0b",
                               payload_item.payload_byte, payload_item.last_byte,
                               payload_item.aborted));
        end else begin
          exp_item = payload_due.pop_front();
          if (payload_item.payload_byte !== exp_item.payload_byte ||
              payload_item.last_byte !== exp_item.last_byte ||
              payload_item.aborted !== exp_item.aborted)
            note_error($sformatf({"mismatch: expected byte %02h last %0b abort %0b,",
                                  " got byte %02h last %0b abort %0b"},
                                 exp_item.payload_byte, exp_item.last_byte,
                                 exp_item.aborted, payload_item.payload_byte,
                                 payload_item.last_byte, payload_item.aborted));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        payload_stall <= 1'b1;
      end else begin
        payload_stall <= 1'b0;
        stall_left = pick_idle(rx_burst);
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (rst || (stream_valid && !stream_stall) || (payload_valid && !payload_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == HANG_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

@@ files.f @@
hdl/wsd_pkg.sv
hdl/wsd_parser.sv
hdl/websocket_text_frame_deframer_top.sv
verif/websocket_text_frame_deframer_top_test.sv
